@@ hdl/hsvrgb_pkg.sv @@
// ============================================================================
// hsvrgb_pkg: shared types and constants for the HSV to RGB converter
// Channel and hue types, fixed-point unit constants and hue sector codes.
// ============================================================================
package hsvrgb_pkg;

   typedef logic [15:0] chan_type;    // Q1.15 channel or Q0.16 hue
   typedef logic [2:0]  sector_type;  // hue sector, floor(6h)
   typedef logic [18:0] hue6_type;    // hue times six, Q3.16

   localparam chan_type   ONE_Q15 = 16'h8000;
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // hue sectors, named by the two colours they run between
   localparam sector_type SEC_RED_YEL = 3'd0;
   localparam sector_type SEC_YEL_GRN = 3'd1;
   localparam sector_type SEC_GRN_CYN = 3'd2;
   localparam sector_type SEC_CYN_BLU = 3'd3;
   localparam sector_type SEC_BLU_MAG = 3'd4;
   localparam sector_type SEC_MAG_RED = 3'd5;

   // limit a Q1.15 quantity to 1.0
   function automatic chan_type sat_one(input chan_type x);
      return (x > ONE_Q15) ? ONE_Q15 : x;
   endfunction

endpackage

@@ hdl/hsv_to_rgb_converter.sv @@
// ============================================================================
// hsv_to_rgb_converter: fixed-point HSV plus alpha to RGB plus alpha
// Four-stage pipeline, one pixel per clock unless rsp_ready stalls, valid/ready on both sides.
// ============================================================================
// Converts a stream of HSV pixels (hue Q0.16, saturation and value Q1.15)
// into RGB Q1.15, passing alpha through untouched. Saturation and value
// above 1.0 are limited to 1.0. The block accepts one pixel per clock
// unless rsp_ready stalls it. The req_ transfer loads stage 1, and the
// pixel then moves through the stage 2, 3 and 4 registers, the last of
// which drives rsp_valid on the rsp_ side. The stage split is set by
// the chain of two multiplier levels: stage 1 forms the sector and hue
// fraction, stage 2 forms s*f, s*(1-f) and p = v*(1-s), stage 3 forms q and
// t, stage 4 picks the channel order and holds the result. Each stage has
// its own valid bit and advances whenever the stage after it is empty or
// moving, so a stall on rsp_ready fills bubbles first and never drops or
// repeats a pixel. Zero saturation needs no special path: p, q and t all
// collapse to v.
module hsv_to_rgb_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hsvrgb_pkg::chan_type req_hue,
   input  hsvrgb_pkg::chan_type req_saturation,
   input  hsvrgb_pkg::chan_type req_brightness,
   input  hsvrgb_pkg::chan_type req_alpha_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hsvrgb_pkg::chan_type rsp_red,
   output hsvrgb_pkg::chan_type rsp_green,
   output hsvrgb_pkg::chan_type rsp_blue,
   output hsvrgb_pkg::chan_type rsp_alpha_out
);
   import hsvrgb_pkg::*;

   // stage enables: a stage loads when it is empty or its successor loads
   logic en1, en2, en3, en4;

   // stage 1: sector, fraction, limited s and v
   logic       valid1_ff;
   sector_type sector1_ff, sector1_in;
   chan_type   f1_ff, f1_in;
   chan_type   s1_ff, s1_in;
   chan_type   v1_ff, v1_in;
   chan_type   a1_ff;
   hue6_type   h6;

   // stage 2: s*f, s*(1-f), p
   logic        valid2_ff;
   sector_type  sector2_ff;
   chan_type    sf2_ff, sf2_in;
   chan_type    sg2_ff, sg2_in;
   chan_type    p2_ff, p2_in;
   chan_type    v2_ff;
   chan_type    a2_ff;
   logic [31:0] sf_prod;
   logic [32:0] sg_prod;
   logic [31:0] p_prod;

   // stage 3: q, t
   logic        valid3_ff;
   sector_type  sector3_ff;
   chan_type    q3_ff, q3_in;
   chan_type    t3_ff, t3_in;
   chan_type    p3_ff;
   chan_type    v3_ff;
   chan_type    a3_ff;
   logic [31:0] q_prod;
   logic [31:0] t_prod;

   // stage 4: output register
   logic     rsp_valid_ff;
   chan_type red_ff, red_in;
   chan_type green_ff, green_in;
   chan_type blue_ff, blue_in;
   chan_type alpha_ff;

   assign en4       = !rsp_valid_ff || rsp_ready;
   assign en3       = !valid3_ff || en4;
   assign en2       = !valid2_ff || en3;
   assign en1       = !valid1_ff || en2;
   assign req_ready = en1;

   // ---- stage 1: hue times six by shift-add, split into sector and f ----
   always_comb begin
      h6         = (hue6_type'(req_hue) << 2) + (hue6_type'(req_hue) << 1);
      sector1_in = h6[18:16];
      f1_in      = h6[15:0];
      s1_in      = sat_one(req_saturation);
      v1_in      = sat_one(req_brightness);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (en1) begin
         valid1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         sector1_ff <= sector1_in;
         f1_ff      <= f1_in;
         s1_ff      <= s1_in;
         v1_ff      <= v1_in;
         a1_ff      <= req_alpha_in;
      end
   end

   // ---- stage 2: first multiplier level ----
   always_comb begin
      sf_prod = 32'(s1_ff) * 32'(f1_ff);
      sg_prod = 33'(s1_ff) * 33'(ONE_Q16 - 17'(f1_ff));
      p_prod  = 32'(v1_ff) * 32'(ONE_Q15 - s1_ff);
      sf2_in  = sf_prod[31:16];
      sg2_in  = sg_prod[31:16];   // s*(1-f) stays at or below 2^31
      p2_in   = p_prod[30:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (en2) begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         sector2_ff <= sector1_ff;
         sf2_ff     <= sf2_in;
         sg2_ff     <= sg2_in;
         p2_ff      <= p2_in;
         v2_ff      <= v1_ff;
         a2_ff      <= a1_ff;
      end
   end

   // ---- stage 3: second multiplier level ----
   always_comb begin
      q_prod = 32'(v2_ff) * 32'(ONE_Q15 - sf2_ff);
      t_prod = 32'(v2_ff) * 32'(ONE_Q15 - sg2_ff);
      q3_in  = q_prod[30:15];
      t3_in  = t_prod[30:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else if (en3) begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         sector3_ff <= sector2_ff;
         q3_ff      <= q3_in;
         t3_ff      <= t3_in;
         p3_ff      <= p2_ff;
         v3_ff      <= v2_ff;
         a3_ff      <= a2_ff;
      end
   end

   // ---- stage 4: route levels to channels by sector ----
   always_comb begin
      case (sector3_ff)
         SEC_RED_YEL: begin
            red_in = v3_ff; green_in = t3_ff; blue_in = p3_ff;
         end
         SEC_YEL_GRN: begin
            red_in = q3_ff; green_in = v3_ff; blue_in = p3_ff;
         end
         SEC_GRN_CYN: begin
            red_in = p3_ff; green_in = v3_ff; blue_in = t3_ff;
         end
         SEC_CYN_BLU: begin
            red_in = p3_ff; green_in = q3_ff; blue_in = v3_ff;
         end
         SEC_BLU_MAG: begin
            red_in = t3_ff; green_in = p3_ff; blue_in = v3_ff;
         end
         default: begin
            red_in = v3_ff; green_in = p3_ff; blue_in = q3_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en4) begin
         rsp_valid_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= a3_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_alpha_out = alpha_ff;

   // ---- assertions ----
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      valid1_ff |-> (sector1_ff <= SEC_MAG_RED))
      else $error("hue sector out of range");

   a_levels_le_v: assert property (@(posedge clock) disable iff (reset)
      valid3_ff |-> (q3_ff <= v3_ff) && (t3_ff <= v3_ff) && (p3_ff <= v3_ff))
      else $error("mixed level above brightness");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (valid3_ff && en4) |=> rsp_valid)
      else $error("pixel lost entering output stage");

   a_hold_stage3: assert property (@(posedge clock) disable iff (reset)
      (valid3_ff && !en4) |=> valid3_ff && $stable(q3_ff) && $stable(t3_ff))
      else $error("stage 3 changed while stalled");

endmodule
